[hdl/sparse_dense_integer_set_top_defines.svh]
// Assertion macros shared by the checker of the sparse-dense integer set.
// Each macro expects clk and rst in the scope where it is used.
`ifndef SPARSE_DENSE_INTEGER_SET_TOP_DEFINES_SVH
`define SPARSE_DENSE_INTEGER_SET_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SDIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SDIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sdis_pkg.sv]
// Package for the sparse-dense integer set: field widths, command codes and
// the control/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package sdis_pkg;

  localparam int CMD_W = 3;
  localparam int ID_W  = 16;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

  localparam logic [ID_W-1:0] NO_VALUE = 16'hFFFF;

  typedef struct packed {
    logic sweep;   // clearing pass: write zero at sweep address
    logic latch;   // transfer accepted: capture command, read sparse and tail
    logic check;   // read dense slot named by the sparse entry
    logic commit;  // write back, update count, load result
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;  // clearing pass at its final entry
    logic out_free;    // result register can take a new result
  } dp_stat_t;

endpackage

[hdl/sdis_ctrl.sv]
// Controller of the sparse-dense integer set: sequences the clearing pass and
// the three phases of each command. Depends on sdis_pkg.
`timescale 1ns / 1ps

module sdis_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sdis_pkg::dp_stat_t   stat,
  output sdis_pkg::ctrl_cmd_t  ctrl
);
  import sdis_pkg::*;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_CHECK,
    ST_EXEC
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // hold here while the previous result is still unclaimed
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

  assign in_ready    = (state == ST_IDLE);
  assign ctrl.sweep  = (state == ST_SWEEP);
  assign ctrl.latch  = in_ready & in_valid;
  assign ctrl.check  = (state == ST_CHECK);
  assign ctrl.commit = (state == ST_EXEC) & stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/sdis_dp.sv]
// Datapath of the sparse-dense integer set: sparse and dense memories, member
// count, command decode and the result register. Depends on sdis_pkg.
`timescale 1ns / 1ps

module sdis_dp #(
  parameter int CAPACITY = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sdis_pkg::ctrl_cmd_t               ctrl,
  output sdis_pkg::dp_stat_t                stat,
  input  logic [sdis_pkg::CMD_W-1:0]        cmd,
  input  logic [sdis_pkg::ID_W-1:0]         element_id,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              ok,
  output logic                              found,
  output logic [sdis_pkg::ID_W-1:0]         popped_value,
  output logic [$clog2(CAPACITY+1)-1:0]     member_total,
  output logic                              set_empty
);
  import sdis_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [ID_W:0]      CAP_ID   = (ID_W + 1)'(CAPACITY);
  localparam logic [CNT_W-1:0]   CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(CAPACITY - 1);

  logic [IDX_W-1:0] sparse_mem [CAPACITY];
  logic [IDX_W-1:0] dense_mem  [CAPACITY];

  logic [CMD_W-1:0] cmd_q;
  logic [ID_W-1:0]  id_q;
  logic [IDX_W-1:0] slot_q;   // sparse entry of the id
  logic [IDX_W-1:0] last_q;   // dense entry at the tail
  logic [IDX_W-1:0] back_q;   // dense entry at slot_q
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] sweep_addr;

  logic [IDX_W-1:0] id_idx;
  logic [IDX_W-1:0] in_idx;
  logic [IDX_W-1:0] tail_idx;
  logic             in_range;
  logic             nonempty;
  logic             member;

  logic             r_ok;
  logic             r_found;
  logic [ID_W-1:0]  r_pop;
  logic [CNT_W-1:0] count_next;
  logic             sp_we;
  logic [IDX_W-1:0] sp_waddr;
  logic [IDX_W-1:0] sp_wdata;
  logic             dn_we;
  logic [IDX_W-1:0] dn_waddr;
  logic [IDX_W-1:0] dn_wdata;

  logic             sp_mem_we;
  logic [IDX_W-1:0] sp_mem_addr;
  logic [IDX_W-1:0] sp_mem_data;
  logic             dn_mem_we;
  logic [IDX_W-1:0] dn_mem_addr;
  logic [IDX_W-1:0] dn_mem_data;

  assign id_idx   = id_q[IDX_W-1:0];
  assign in_idx   = element_id[IDX_W-1:0];
  assign in_range = {1'b0, id_q} < CAP_ID;
  assign nonempty = (count != '0);
  assign tail_idx = nonempty ? IDX_W'(count - CNT_W'(1)) : '0;
  // member only if the sparse entry points below the count at a slot that
  // holds the id back
  assign member   = in_range && (CNT_W'(slot_q) < count) && (back_q == id_idx);

  assign stat.sweep_last = (sweep_addr == LAST_IDX);
  assign stat.out_free   = ~out_valid | out_ready;

  always_comb begin
    r_ok       = 1'b0;
    r_found    = 1'b0;
    r_pop      = NO_VALUE;
    count_next = count;
    sp_we      = 1'b0;
    sp_waddr   = id_idx;
    sp_wdata   = IDX_W'(count);
    dn_we      = 1'b0;
    dn_waddr   = IDX_W'(count);
    dn_wdata   = id_idx;
    case (cmd_q)
      CMD_INSERT: begin
        if (in_range) begin
          r_ok    = 1'b1;
          r_found = member;
          if (!member && (count < CAP_CNT)) begin
            sp_we      = 1'b1;
            dn_we      = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
      end
      CMD_REMOVE: begin
        if (in_range && nonempty) begin
          r_ok    = 1'b1;
          r_found = member;
          if (member) begin
            // move the tail member into the freed slot
            dn_we      = 1'b1;
            dn_waddr   = slot_q;
            dn_wdata   = last_q;
            sp_we      = 1'b1;
            sp_waddr   = last_q;
            sp_wdata   = slot_q;
            count_next = count - CNT_W'(1);
          end
        end
      end
      CMD_CONTAINS: begin
        if (in_range) begin
          r_ok    = 1'b1;
          r_found = member;
        end
      end
      CMD_POP: begin
        if (nonempty) begin
          r_ok       = 1'b1;
          r_found    = 1'b1;
          count_next = count - CNT_W'(1);
          r_pop      = ID_W'(last_q);
        end
      end
      CMD_CLEAR: begin
        r_ok       = 1'b1;
        count_next = '0;
      end
      default: begin
        r_ok = 1'b0;
      end
    endcase
  end

  assign sp_mem_we   = ctrl.sweep | (ctrl.commit & sp_we);
  assign sp_mem_addr = ctrl.sweep ? sweep_addr : sp_waddr;
  assign sp_mem_data = ctrl.sweep ? '0 : sp_wdata;
  assign dn_mem_we   = ctrl.sweep | (ctrl.commit & dn_we);
  assign dn_mem_addr = ctrl.sweep ? sweep_addr : dn_waddr;
  assign dn_mem_data = ctrl.sweep ? '0 : dn_wdata;

  always_ff @(posedge clk) begin
    if (sp_mem_we) sparse_mem[sp_mem_addr] <= sp_mem_data;
    if (ctrl.latch) slot_q <= sparse_mem[in_idx];
  end

  always_ff @(posedge clk) begin
    if (dn_mem_we) dense_mem[dn_mem_addr] <= dn_mem_data;
    if (ctrl.latch) last_q <= dense_mem[tail_idx];
    if (ctrl.check) back_q <= dense_mem[slot_q];
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_q <= cmd;
      id_q  <= element_id;
    end
    if (ctrl.commit) begin
      ok           <= r_ok;
      found        <= r_found;
      popped_value <= r_pop;
      member_total <= count_next;
      set_empty    <= (count_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      out_valid  <= 1'b0;
      sweep_addr <= '0;
    end else begin
      if (ctrl.sweep) sweep_addr <= sweep_addr + IDX_W'(1);
      if (ctrl.commit) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/sparse_dense_integer_set_top.sv]
// Top level of the sparse-dense integer set: joins the controller and the
// datapath. Depends on sdis_pkg, sdis_ctrl and sdis_dp.
`timescale 1ns / 1ps

// Sparse-dense integer set over ids 0..CAPACITY-1 with one result per command
// (insert, remove, contains, pop last, clear). After reset the block runs a
// clearing pass over both memories, with in_ready low, then takes commands.
// From transfer to result, the transfer cycle reads the sparse entry of the
// id and the tail of the dense memory, the next cycle reads the dense slot
// that the sparse entry names, and the write-back cycle checks membership,
// writes both memories back, updates the count and loads the result register.
// No new command is taken until that write-back. A result waits in its output
// register while the next command is taken; the block holds in its write-back
// cycle only while an earlier result is still unclaimed. For insert, remove
// and contains, ids at or above CAPACITY give ok low and leave the set as it
// is.
module sparse_dense_integer_set_top #(
  parameter int CAPACITY = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sdis_pkg::CMD_W-1:0]    cmd,
  input  logic [sdis_pkg::ID_W-1:0]     element_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic                          found,
  output logic [sdis_pkg::ID_W-1:0]     popped_value,
  output logic [$clog2(CAPACITY+1)-1:0] member_total,
  output logic                          set_empty
);
  import sdis_pkg::*;

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;

  // Sequence the clearing pass and the read, check and write-back phases.
  sdis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Hold the memories, the count and the result register.
  sdis_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .cmd          (cmd),
    .element_id   (element_id),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .ok           (ok),
    .found        (found),
    .popped_value (popped_value),
    .member_total (member_total),
    .set_empty    (set_empty)
  );

endmodule

[hdl/sdis_checker.sv]
// Port-level checker for the sparse-dense integer set, bound to the top level.
// Depends on sparse_dense_integer_set_top_defines.svh and sdis_pkg.
`timescale 1ns / 1ps
`include "sparse_dense_integer_set_top_defines.svh"

module sdis_checker #(
  parameter int CAPACITY = 1024
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          ok,
  input logic                          found,
  input logic [$clog2(CAPACITY+1)-1:0] member_total
);
  import sdis_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  `SDIS_ASSERT_NXT(a_busy_after_transfer, in_valid && in_ready, !in_ready, "ready after transfer")
  `SDIS_ASSERT_IMP(a_result_from_work, $rose(out_valid), !$past(in_ready), "result while idle")
  `SDIS_ASSERT_IMP(a_found_needs_ok, out_valid && found, ok, "found without ok")
  `SDIS_ASSERT_IMP(a_total_bound, out_valid, member_total <= CAP_CNT, "count above capacity")
  `SDIS_ASSERT_NXT(a_out_held, out_valid && !out_ready, out_valid, "result dropped")

endmodule

bind sparse_dense_integer_set_top sdis_checker #(
  .CAPACITY (CAPACITY)
) u_sdis_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .ok           (ok),
  .found        (found),
  .member_total (member_total)
);

[dv/testbench.sv]
// Self-checking testbench for sparse_dense_integer_set_top: a directed table
// followed by random command streams under varying idle patterns.
// Depends on sdis_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module testbench;
  import sdis_pkg::*;

  localparam int CAPACITY = 1024;
  localparam int TOTAL_W = $clog2(CAPACITY + 1);
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PER_STRETCH = 140;

  // Command codes the block does not define; it must answer them with ok low.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic              ok;
    logic              found;
    logic [ID_W-1:0]   popped;
    logic [TOTAL_W-1:0] total;
    logic              empty;
  } set_result_t;

  typedef struct {
    logic [CMD_W-1:0] op;
    logic [ID_W-1:0]  id;
    bit               typed;  // use the hand-written answer instead of the predictor
    set_result_t      want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [CMD_W-1:0]   cmd = '0;
  logic [ID_W-1:0]    element_id = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               ok;
  logic               found;
  logic [ID_W-1:0]    popped_value;
  logic [TOTAL_W-1:0] member_total;
  logic               set_empty;

  // Shadow copy of the set: id -> dense slot, slot -> id, and the live count.
  int unsigned slot_of_id [CAPACITY];
  int unsigned id_at_slot [CAPACITY];
  int unsigned live_count = 0;

  set_result_t pending_results[$];

  int errors = 0;
  int results_checked = 0;
  int commands_sent = 0;
  int found_hits = 0;
  int pops_with_value = 0;
  int peak_members = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_requests = 0;
  int quiet_cycles = 0;

  sparse_dense_integer_set_top #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .element_id  (element_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .found       (found),
    .popped_value(popped_value),
    .member_total(member_total),
    .set_empty   (set_empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // An id belongs to the set only when its slot is live and points back at it,
  // so stale entries left by remove, pop or clear never count.
  function automatic bit is_live(input int unsigned id);
    int unsigned slot;
    if (id >= CAPACITY) return 1'b0;
    slot = slot_of_id[id];
    if (slot >= live_count) return 1'b0;
    return id_at_slot[slot] == id;
  endfunction

  // Apply one command to the shadow set and return the result it must produce.
  function automatic set_result_t apply_set_command(input logic [CMD_W-1:0] op,
                                                    input logic [ID_W-1:0] id);
    set_result_t r;
    bit          in_range;
    int unsigned slot;
    int unsigned tail_id;
    r = '{ok: 1'b0, found: 1'b0, popped: NO_VALUE, total: '0, empty: 1'b0};
    in_range = id < CAPACITY;
    case (op)
      CMD_INSERT: begin
        if (in_range) begin
          r.ok = 1'b1;
          if (is_live(id)) begin
            r.found = 1'b1;
          end else if (live_count < CAPACITY) begin
            slot_of_id[id] = live_count;
            id_at_slot[live_count] = id;
            live_count++;
          end
        end
      end
      CMD_REMOVE: begin
        if (in_range && live_count != 0) begin
          r.ok = 1'b1;
          if (is_live(id)) begin
            // move the tail member into the freed slot
            slot = slot_of_id[id];
            tail_id = id_at_slot[live_count - 1];
            r.found = 1'b1;
            id_at_slot[slot] = tail_id;
            slot_of_id[tail_id] = slot;
            live_count--;
          end
        end
      end
      CMD_CONTAINS: begin
        if (in_range) begin
          r.ok = 1'b1;
          r.found = is_live(id);
        end
      end
      CMD_POP: begin
        if (live_count != 0) begin
          r.ok = 1'b1;
          r.found = 1'b1;
          live_count--;
          r.popped = ID_W'(id_at_slot[live_count]);
        end
      end
      CMD_CLEAR: begin
        r.ok = 1'b1;
        live_count = 0;
      end
      default: begin
      end
    endcase
    r.total = TOTAL_W'(live_count);
    r.empty = live_count == 0;
    return r;
  endfunction

  // Offer one command: optionally idle first, then hold valid and payload until
  // the transfer, then record what the block must answer.
  task automatic send_command(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
                              input bit typed, input set_result_t fixed);
    int          gap;
    set_result_t predicted;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    element_id <= id;
    do @(posedge clk); while (!in_ready);
    predicted = apply_set_command(op, id);
    pending_results.push_back(typed ? fixed : predicted);
    commands_sent++;
    if (predicted.found) found_hits++;
    if (predicted.popped != NO_VALUE) pops_with_value++;
    if (live_count > peak_members) peak_members = live_count;
  endtask

  // Drop valid and wait until every answer owed by the block has arrived.
  // Always advance at least one edge so valid is never driven twice in a step.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Random commands: mostly small ids so that hits on live members are common,
  // with full-range ids and the capacity boundary mixed in.
  task automatic send_random_commands(input int count);
    logic [CMD_W-1:0] op;
    logic [ID_W-1:0]  id;
    int unsigned      roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 38) op = CMD_INSERT;
      else if (roll < 58) op = CMD_REMOVE;
      else if (roll < 80) op = CMD_CONTAINS;
      else if (roll < 92) op = CMD_POP;
      else if (roll < 95) op = CMD_CLEAR;
      else op = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
      roll = $urandom_range(99);
      if (roll < 60) id = ID_W'($urandom_range(31));
      else if (roll < 86) id = ID_W'($urandom_range(CAPACITY - 1));
      else if (roll < 91) id = ($urandom_range(1) != 0) ? ID_W'(CAPACITY) : ID_W'(CAPACITY - 1);
      else id = ID_W'($urandom_range(16'hFFFF));
      send_command(op, id, 1'b0, '0);
    end
  endtask

  // Receiver: stall at random, and serve a long hold-off when one is requested
  // so the block backs up and stalls its input side.
  initial begin : result_sink
    int stall_left;
    int hold_offs_served;
    stall_left = 0;
    hold_offs_served = 0;
    forever begin
      @(posedge clk);
      if (hold_offs_served != hold_off_requests) begin
        hold_offs_served = hold_off_requests;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  // Compare each result transfer with the oldest outstanding answer.
  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    set_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result transfer with nothing outstanding", $time);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("ok", want.ok, ok);
        compare_field("found", want.found, found);
        compare_field("popped_value", want.popped, popped_value);
        compare_field("member_total", want.total, member_total);
        compare_field("set_empty", want.empty, set_empty);
        results_checked++;
      end
    end
  end

  // Watchdog: end the run when no transfer happens on either side for too long.
  // The limit covers the clearing pass after reset and the long hold-off.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_results.size());
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t   rows[$];

    // Directed table. Rows with typed answers are plain enough to read off by
    // eye; the rest go through the shadow set.
    rows.push_back('{CMD_CONTAINS, 16'd0, 1'b1, '{1'b1, 1'b0, NO_VALUE, TOTAL_W'(0), 1'b1}});
    rows.push_back('{CMD_POP, 16'd0, 1'b1, '{1'b0, 1'b0, NO_VALUE, TOTAL_W'(0), 1'b1}});
    rows.push_back('{CMD_REMOVE, 16'd5, 1'b1, '{1'b0, 1'b0, NO_VALUE, TOTAL_W'(0), 1'b1}});
    rows.push_back('{CMD_INSERT, 16'hFFFF, 1'b1, '{1'b0, 1'b0, NO_VALUE, TOTAL_W'(0), 1'b1}});
    rows.push_back('{CMD_INSERT, 16'(CAPACITY), 1'b1,
                     '{1'b0, 1'b0, NO_VALUE, TOTAL_W'(0), 1'b1}});
    rows.push_back('{CMD_INSERT, 16'd0, 1'b1, '{1'b1, 1'b0, NO_VALUE, TOTAL_W'(1), 1'b0}});
    rows.push_back('{CMD_INSERT, 16'(CAPACITY - 1), 1'b1,
                     '{1'b1, 1'b0, NO_VALUE, TOTAL_W'(2), 1'b0}});
    rows.push_back('{CMD_INSERT, 16'd0, 1'b1, '{1'b1, 1'b1, NO_VALUE, TOTAL_W'(2), 1'b0}});
    rows.push_back('{CMD_CONTAINS, 16'(CAPACITY - 1), 1'b0, '0});
    rows.push_back('{CMD_CONTAINS, 16'(CAPACITY), 1'b1,
                     '{1'b0, 1'b0, NO_VALUE, TOTAL_W'(2), 1'b0}});
    rows.push_back('{CMD_INSERT, 16'd512, 1'b0, '0});
    rows.push_back('{CMD_REMOVE, 16'd7, 1'b0, '0});        // non-member, set not empty
    rows.push_back('{CMD_REMOVE, 16'd0, 1'b0, '0});        // tail member moves into slot 0
    rows.push_back('{CMD_CONTAINS, 16'd512, 1'b0, '0});
    rows.push_back('{CMD_CONTAINS, 16'd0, 1'b0, '0});
    rows.push_back('{CMD_POP, 16'hFFFF, 1'b0, '0});
    rows.push_back('{CMD_REMOVE, 16'hFFFF, 1'b0, '0});
    rows.push_back('{CMD_SPARE_FIRST, 16'd1, 1'b0, '0});
    rows.push_back('{CMD_SPARE_MID, 16'hAAAA, 1'b0, '0});
    rows.push_back('{CMD_SPARE_LAST, 16'h5555, 1'b0, '0});
    rows.push_back('{CMD_CLEAR, 16'h1234, 1'b1, '{1'b1, 1'b0, NO_VALUE, TOTAL_W'(0), 1'b1}});
    // stale entries left behind by clear must not make 512 look present
    rows.push_back('{CMD_CONTAINS, 16'd512, 1'b1, '{1'b1, 1'b0, NO_VALUE, TOTAL_W'(0), 1'b1}});
    rows.push_back('{CMD_INSERT, 16'd512, 1'b0, '0});
    rows.push_back('{CMD_POP, 16'd0, 1'b0, '0});
    rows.push_back('{CMD_INSERT, 16'd1, 1'b0, '0});

    // Hold reset, then release it; the block then sweeps its memories on its own.
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // First stretch: sender idles lightly, receiver stalls heavily.
    send_idle_pct = 27;
    recv_idle_pct = 63;
    foreach (rows[k]) send_command(rows[k].op, rows[k].id, rows[k].typed, rows[k].want);
    send_random_commands(RANDOM_PER_STRETCH);
    wait_for_results();

    // Second stretch: roles swapped.
    send_idle_pct = 63;
    recv_idle_pct = 27;
    send_random_commands(RANDOM_PER_STRETCH);
    wait_for_results();

    // Third stretch: no random idling, but open with a long receiver hold-off
    // while commands keep coming, so the block fills and stalls its input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_requests++;
    send_random_commands(RANDOM_PER_STRETCH);

    // Close with a clear and a pop on the emptied set.
    send_command(CMD_CLEAR, '0, 1'b0, '0);
    send_command(CMD_POP, '0, 1'b0, '0);

    // Drain, let the pipeline settle, and make sure nothing else shows up.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pending_results.size());
      errors++;
    end

    $display("summary: %0d commands, %0d results checked, %0d mismatches",
             commands_sent, results_checked, errors);
    $display("summary: %0d hits on members, %0d values popped, peak membership %0d",
             found_hits, pops_with_value, peak_members);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
